// ----- rtl/core/rpwd_pkg.sv -----
// Shared constants and types for the RC PWM pulse-width decoder.
package rpwd_pkg;

  localparam int CHANNEL_COUNT = 7;      // decoded channels, 1..12
  localparam int NUM_OUT_CH    = 7;      // channels with an output field
  localparam int ACTIVE_CH     = (CHANNEL_COUNT > NUM_OUT_CH) ? NUM_OUT_CH : CHANNEL_COUNT;

  localparam int TS_W    = 16;
  localparam int VALUE_W = 10;
  localparam int MASK_W  = NUM_OUT_CH;

  localparam int IN_DATA_W  = 24;        // 7 + 16 bits, padded to bytes
  localparam int OUT_DATA_W = 80;        // 7 x 10 + 7 bits, padded to bytes

  localparam logic [TS_W-1:0] WIDTH_MIN    = 16'd1000;
  localparam logic [TS_W-1:0] WIDTH_MAX    = 16'd2000;
  localparam logic [10:0]     WIDTH_CENTER = 11'd1500;

  localparam logic signed [VALUE_W-1:0] VALUE_LOW  = -10'sd500;
  localparam logic signed [VALUE_W-1:0] VALUE_HIGH = 10'sd500;
  localparam logic signed [VALUE_W-1:0] CH0_RESET_VALUE = -10'sd500;

  localparam logic [MASK_W-1:0] INVERT_RESET = 7'd10;

  // per-channel control from the pipeline to a channel cell
  typedef struct packed {
    logic load;     // stage 1 transaction moves to the output register
    logic pin;      // sampled level of this channel
    logic invert;   // negate this channel's decode
  } rpwd_chan_ctl_t;

  // per-channel status back to the top level
  typedef struct packed {
    logic level;    // level seen in the last sample
    logic done;     // falling edge in the last sample
  } rpwd_chan_sts_t;

endpackage

// ----- rtl/core/rpwd_chan.sv -----
// One channel cell: edge detect, pulse start capture, width clamp and value store.
module rpwd_chan (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  rpwd_pkg::rpwd_chan_ctl_t               ctl,
  input  logic [rpwd_pkg::TS_W-1:0]              ts,
  input  logic signed [rpwd_pkg::VALUE_W-1:0]    rst_value,
  output rpwd_pkg::rpwd_chan_sts_t               sts,
  output logic signed [rpwd_pkg::VALUE_W-1:0]    value
);
  import rpwd_pkg::*;

  logic                      level_r, level_nxt;
  logic                      done_r, done_nxt;
  logic [TS_W-1:0]           start_r, start_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;

  logic [TS_W-1:0]           width;
  logic [10:0]               diff;
  logic signed [VALUE_W-1:0] decoded;
  logic                      rise, fall;

  assign rise  = ctl.pin & ~level_r;
  assign fall  = ~ctl.pin & level_r;
  assign width = ts - start_r;          // wraps modulo 2^16
  assign diff  = width[10:0] - WIDTH_CENTER;

  always_comb begin
    priority if (width < WIDTH_MIN) begin
      decoded = VALUE_LOW;
    end else if (width > WIDTH_MAX) begin
      decoded = VALUE_HIGH;
    end else begin
      decoded = signed'(diff[VALUE_W-1:0]);
    end
  end

  always_comb begin
    level_nxt = level_r;
    done_nxt  = done_r;
    start_nxt = start_r;
    value_nxt = value_r;
    if (ctl.load) begin
      level_nxt = ctl.pin;
      done_nxt  = fall;
      if (rise) begin
        start_nxt = ts;
      end
      if (fall) begin
        value_nxt = ctl.invert ? -decoded : decoded;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b0;
      done_r  <= 1'b0;
      start_r <= '0;
      value_r <= rst_value;
    end else begin
      level_r <= level_nxt;
      done_r  <= done_nxt;
      start_r <= start_nxt;
      value_r <= value_nxt;
    end
  end

  assign sts.level = level_r;
  assign sts.done  = done_r;
  assign value     = value_r;

endmodule

// ----- rtl/core/rc_pwm_pulse_width_decoder_core.sv -----
// Top level of the RC PWM pulse-width decoder: input register, channel cells, output stage.
//
//  Port group | Dir | Payload (low bit up)
//  -----------+-----+-----------------------------------------------------------
//  in_*       | in  | tdata: pin_levels[6:0], timestamp_us[22:7]
//  out_*      | out | tdata: throttle, rudder, elevator, aileron, aux_one,
//             |     |        aux_two, aux_three (10b each), updated_mask[76:70]
//  cfg_*      | in  | wr_data: invert_mask[6:0]
//
// One sample per clock while the output is not stalled. It passes the input register,
// then the channel cells, whose state registers double as the output register.
// Edge handling and the width clamp are two subtracts and two compares per
// channel. A stall on out_tready holds both stages; in_tready drops only when
// both are full. Reset is synchronous.
module rc_pwm_pulse_width_decoder_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rpwd_pkg::IN_DATA_W-1:0]      in_tdata,   // pin_levels, timestamp_us
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rpwd_pkg::OUT_DATA_W-1:0]     out_tdata,  // 7 channel values, updated_mask
  input  logic                                cfg_wr_en,
  input  logic [rpwd_pkg::MASK_W-1:0]         cfg_wr_data // invert_mask
);
  import rpwd_pkg::*;

  logic                s1_valid_r, s1_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]   s1_pins_r;
  logic [TS_W-1:0]     s1_ts_r;
  logic [MASK_W-1:0]   invert_mask_r;
  logic                advance;
  logic                in_fire;
  logic                load;

  logic signed [VALUE_W-1:0] ch_value [NUM_OUT_CH];
  logic [MASK_W-1:0]         levels;
  logic [MASK_W-1:0]         updated;

  assign advance   = ~out_valid_r | out_tready;
  assign load      = s1_valid_r & advance;
  assign in_tready = ~s1_valid_r | advance;
  assign in_fire   = in_tvalid & in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      invert_mask_r <= INVERT_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        invert_mask_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pins_r <= in_tdata[MASK_W-1:0];
      s1_ts_r   <= in_tdata[MASK_W +: TS_W];
    end
  end

  for (genvar n = 0; n < NUM_OUT_CH; n++) begin : g_ch
    if (n < ACTIVE_CH) begin : g_on
      rpwd_chan_ctl_t ctl;
      rpwd_chan_sts_t sts;

      assign ctl.load   = load;
      assign ctl.pin    = s1_pins_r[n];
      assign ctl.invert = invert_mask_r[n];

      rpwd_chan u_chan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .ts        (s1_ts_r),
        .rst_value ((n == 0) ? CH0_RESET_VALUE : VALUE_W'(0)),
        .sts       (sts),
        .value     (ch_value[n])
      );

      assign levels[n]  = sts.level;
      assign updated[n] = sts.done;
    end else begin : g_off
      assign ch_value[n] = '0;
      assign levels[n]   = 1'b0;
      assign updated[n]  = 1'b0;
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int n = 0; n < NUM_OUT_CH; n++) begin
      out_tdata[n*VALUE_W +: VALUE_W] = ch_value[n];
    end
    out_tdata[NUM_OUT_CH*VALUE_W +: MASK_W] = updated;
  end

  assign out_tvalid = out_valid_r;

  // a channel only reports a finished pulse when its last level is low
  a_upd_low: assert property (@(posedge clk) disable iff (!rst_n)
    (updated & levels) == '0)
    else $error("updated channel with high level");

  // input side only stalls when both stages are full and the output is held
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("in_tready low without back-pressure");

  // channel state does not move while the output is stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (levels == $past(levels) && updated == $past(updated)))
    else $error("channel state changed during stall");

  // nothing is pending right after reset
  a_rst: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (!out_tvalid && !s1_valid_r))
    else $error("pipeline not empty after reset");

endmodule

// ----- verif/rc_pwm_pulse_width_decoder_core_tb.sv -----
// Self-checking testbench for the RC PWM pulse-width decoder core.
module rc_pwm_pulse_width_decoder_core_tb;
  import rpwd_pkg::*;

  localparam int WDOG_LIMIT  = 2000;  // cycles without any transaction
  localparam int LONG_HOLD   = 120;   // receiver hold-off in cycles
  localparam int PHASE_ITEMS = 227;
  localparam int PHASES      = 5;
  localparam int DIR_ROWS    = 17;
  localparam int MAX_REPORTS = 10;

  typedef logic [OUT_DATA_W-1:0] word_t;

  typedef struct packed {
    logic [NUM_OUT_CH-1:0]             pins;
    logic [TS_W-1:0]                   ts;
    logic                              known;  // expectation typed in below
    logic [MASK_W-1:0]                 umask;
    logic [NUM_OUT_CH-1:0][VALUE_W-1:0] vals;  // channel 0 in the low bits
  } dir_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [MASK_W-1:0]      cfg_wr_data = '0;

  // tag travelling with the offered transaction
  logic  cur_known = 1'b0;
  word_t cur_exp = '0;

  // decoder state as the testbench sees it
  logic [NUM_OUT_CH-1:0] last_pins;
  logic [TS_W-1:0]       rise_ts [NUM_OUT_CH];
  int                    chan_val [NUM_OUT_CH];
  logic [MASK_W-1:0]     inv_mask;

  word_t    pending_results [$];
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       burst_left = 0;
  bit       hold_req = 1'b0;
  dir_row_t dir_tab [DIR_ROWS];
  string    ch_name [NUM_OUT_CH] = '{"throttle", "rudder", "elevator", "aileron",
                                     "aux_one", "aux_two", "aux_three"};

  rc_pwm_pulse_width_decoder_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_t decode_sample(input logic [NUM_OUT_CH-1:0] pins,
                                          input logic [TS_W-1:0] ts);
    logic [NUM_OUT_CH-1:0] flips;
    logic [MASK_W-1:0]     done;
    logic [TS_W-1:0]       span;
    int                    w;
    word_t                 r;
    flips = pins ^ last_pins;
    last_pins = pins;
    done = '0;
    r = '0;
    for (int n = 0; n < ACTIVE_CH; n++) begin
      if (flips[n]) begin
        if (pins[n]) begin
          rise_ts[n] = ts;
        end else begin
          span = ts - rise_ts[n];  // wraps modulo 2^16
          w = int'(span);
          if (w < int'(WIDTH_MIN)) w = int'(WIDTH_MIN);
          if (w > int'(WIDTH_MAX)) w = int'(WIDTH_MAX);
          w = w - int'(WIDTH_CENTER);
          if (inv_mask[n]) w = -w;
          chan_val[n] = w;
          done[n] = 1'b1;
        end
      end
    end
    for (int n = 0; n < NUM_OUT_CH; n++) begin
      if (n < ACTIVE_CH) r[VALUE_W*n +: VALUE_W] = chan_val[n][VALUE_W-1:0];
    end
    r[VALUE_W*NUM_OUT_CH +: MASK_W] = done;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s: expected %0d, got %0d", field, want, got);
  endtask

  // result checking and prediction on accepted transactions
  always @(posedge clk) begin
    word_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, updated_mask", -1,
                          int'(out_tdata[VALUE_W*NUM_OUT_CH +: MASK_W]));
        end else begin
          want = pending_results.pop_front();
          for (int n = 0; n < NUM_OUT_CH; n++) begin
            if (out_tdata[VALUE_W*n +: VALUE_W] !== want[VALUE_W*n +: VALUE_W])
              report_mismatch(ch_name[n], int'($signed(want[VALUE_W*n +: VALUE_W])),
                              int'($signed(out_tdata[VALUE_W*n +: VALUE_W])));
          end
          if (out_tdata[VALUE_W*NUM_OUT_CH +: MASK_W] !==
              want[VALUE_W*NUM_OUT_CH +: MASK_W])
            report_mismatch("updated_mask", int'(want[VALUE_W*NUM_OUT_CH +: MASK_W]),
                            int'(out_tdata[VALUE_W*NUM_OUT_CH +: MASK_W]));
        end
      end
      if (in_tvalid && in_tready) begin
        want = decode_sample(in_tdata[NUM_OUT_CH-1:0], in_tdata[NUM_OUT_CH +: TS_W]);
        pending_results.push_back(cur_known ? cur_exp : want);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
      $display("rc_pwm_pulse_width_decoder_core_tb: done, errors");
      $finish;
    end
  end

  // receiver: segments of different stall patterns, one long hold-off on request
  initial begin
    rx_mode_t mode;
    int       seg;
    int       k;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      seg = $urandom_range(20, 200);
      for (k = 0; k < seg; k++) begin
        if (hold_req) begin
          out_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_EVERY4: out_tready <= (k % 4 != 0);
          default:   out_tready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic offer(input logic [NUM_OUT_CH-1:0] pins, input logic [TS_W-1:0] ts,
                       input logic known, input word_t exp_word);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-TS_W-NUM_OUT_CH){1'b0}}, ts, pins};
    cur_known <= known;
    cur_exp   <= exp_word;
    do @(posedge clk); while (!in_tready);
  endtask

  // bursts of random length, random gaps between them
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_invert(input logic [MASK_W-1:0] m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    inv_mask = m;
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    localparam logic [VALUE_W-1:0] Z = '0;
    localparam logic [VALUE_W-1:0] H = VALUE_HIGH;
    localparam logic [VALUE_W-1:0] L = VALUE_LOW;
    logic [NUM_OUT_CH-1:0] pins;
    logic [TS_W-1:0]       ts;
    logic [NUM_OUT_CH-1:0] gen_lvl;
    int                    sim_us;
    int                    edge_at [NUM_OUT_CH];
    logic [MASK_W-1:0]     phase_mask;

    // value columns run from aux_three down to throttle
    dir_tab[0]  = '{7'h00, 16'd0,     1'b1, 7'h00, {Z, Z, Z, Z, Z, Z, CH0_RESET_VALUE}};
    dir_tab[1]  = '{7'h7F, 16'd100,   1'b1, 7'h00, {Z, Z, Z, Z, Z, Z, CH0_RESET_VALUE}};
    dir_tab[2]  = '{7'h00, 16'd1600,  1'b1, 7'h7F, {Z, Z, Z, Z, Z, Z, Z}};  // exact center
    dir_tab[3]  = '{7'h7F, 16'd65000, 1'b1, 7'h00, {Z, Z, Z, Z, Z, Z, Z}};
    dir_tab[4]  = '{7'h00, 16'd464,   1'b1, 7'h7F, {L, L, L, H, L, H, L}};  // wraps to 1000
    dir_tab[5]  = '{7'h7F, 16'd10,    1'b1, 7'h00, {L, L, L, H, L, H, L}};
    dir_tab[6]  = '{7'h00, 16'd3000,  1'b1, 7'h7F, {H, H, H, L, H, L, H}};  // clamps high
    dir_tab[7]  = '{7'h55, 16'd200,   1'b0, 7'h00, '0};
    dir_tab[8]  = '{7'h7F, 16'd900,   1'b0, 7'h00, '0};
    dir_tab[9]  = '{7'h2A, 16'd1900,  1'b0, 7'h00, '0};
    dir_tab[10] = '{7'h00, 16'd2100,  1'b0, 7'h00, '0};
    dir_tab[11] = '{7'h7F, 16'd5000,  1'b0, 7'h00, '0};
    dir_tab[12] = '{7'h7E, 16'd5999,  1'b0, 7'h00, '0};  // one below the low bound
    dir_tab[13] = '{7'h7C, 16'd6001,  1'b0, 7'h00, '0};
    dir_tab[14] = '{7'h78, 16'd6999,  1'b0, 7'h00, '0};
    dir_tab[15] = '{7'h70, 16'd7001,  1'b0, 7'h00, '0};  // one above the high bound
    dir_tab[16] = '{7'h00, 16'd5000,  1'b0, 7'h00, '0};  // zero width

    last_pins = '0;
    inv_mask  = INVERT_RESET;
    for (int n = 0; n < NUM_OUT_CH; n++) begin
      rise_ts[n]  = '0;
      chan_val[n] = 0;
      edge_at[n]  = $urandom_range(0, 3000);
    end
    chan_val[0] = int'(CH0_RESET_VALUE);
    gen_lvl = '0;
    sim_us  = 0;
    burst_left = $urandom_range(1, 30);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIR_ROWS; k++) begin
      offer(dir_tab[k].pins, dir_tab[k].ts, dir_tab[k].known,
            {{(OUT_DATA_W-MASK_W-VALUE_W*NUM_OUT_CH){1'b0}}, dir_tab[k].umask,
             dir_tab[k].vals});
      pace_sender();
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_mask = '0;
        1:       phase_mask = '1;
        default: phase_mask = MASK_W'($urandom_range(0, 127));
      endcase
      set_invert(phase_mask);
      if (p == 1) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: arbitrary levels and time
          pins = NUM_OUT_CH'($urandom_range(0, 127));
          ts   = TS_W'($urandom_range(0, 65535));
        end else begin
          if ($urandom_range(0, 19) == 0)
            sim_us += $urandom_range(500, 70000);
          else
            sim_us += $urandom_range(1, 120);
          for (int n = 0; n < NUM_OUT_CH; n++) begin
            if (sim_us >= edge_at[n]) begin
              gen_lvl[n] = ~gen_lvl[n];
              if (gen_lvl[n])
                edge_at[n] = sim_us + (($urandom_range(0, 4) == 0) ?
                             $urandom_range(0, 3000) : $urandom_range(980, 2020));
              else
                edge_at[n] = sim_us + $urandom_range(200, 4000);
            end
          end
          pins = gen_lvl;
          ts   = sim_us[TS_W-1:0];
        end
        offer(pins, ts, 1'b0, '0);
        pace_sender();
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end
    if (mismatches == 0)
      $display("rc_pwm_pulse_width_decoder_core_tb: done, clean");
    else
      $display("rc_pwm_pulse_width_decoder_core_tb: done, errors");
    $finish;
  end

endmodule
